@@ sv/ps2_mouse_packet_tracker_assert.svh @@
// ----------------------------------------------------------------------------
// ps2 mouse packet tracker assertion macros
// shorthand for clocked, reset-qualified concurrent checks
// ----------------------------------------------------------------------------
`ifndef PS2_MOUSE_PACKET_TRACKER_ASSERT_SVH
`define PS2_MOUSE_PACKET_TRACKER_ASSERT_SVH

// same-cycle implication
`define PS2MT_ASSERT_IMPLIES(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ps2mt check failed");

// next-cycle implication
`define PS2MT_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ps2mt check failed");

`endif

@@ sv/ps2mt_pkg.sv @@
// ----------------------------------------------------------------------------
// ps2mt_pkg
// shared constants, types and helpers of the ps2 mouse packet tracker
// ----------------------------------------------------------------------------
package ps2mt_pkg;

    // wheel fifo geometry
    localparam int WHEEL_DEPTH = 64;
    localparam int WHEEL_AW    = (WHEEL_DEPTH > 1) ? $clog2(WHEEL_DEPTH) : 1;

    // cursor geometry
    localparam int COORD_BITS = 12;
    localparam int BOUND_BITS = COORD_BITS + 1;
    localparam int SUM_BITS   = COORD_BITS + 2;

    localparam logic [BOUND_BITS-1:0] BOUND_FULL  = {1'b1, {COORD_BITS{1'b0}}};
    localparam logic [COORD_BITS-1:0] COORD_MAX   = {COORD_BITS{1'b1}};

    // reset values
    localparam logic [BOUND_BITS-1:0] WIDTH_RESET  = BOUND_BITS'(320);
    localparam logic [BOUND_BITS-1:0] HEIGHT_RESET = BOUND_BITS'(200);
    localparam logic [COORD_BITS-1:0] POS_X_RESET  = COORD_BITS'(160);
    localparam logic [COORD_BITS-1:0] POS_Y_RESET  = COORD_BITS'(100);

    // header byte bits
    localparam int SYNC_BIT    = 3;
    localparam int X_SIGN_BIT  = 4;
    localparam int Y_SIGN_BIT  = 5;

    // packet positions
    localparam logic [1:0] POS_HEADER = 2'd0;
    localparam logic [1:0] POS_X      = 2'd1;
    localparam logic [1:0] POS_Y      = 2'd2;
    localparam logic [2:0] LEN_PLAIN  = 3'd3;
    localparam logic [2:0] LEN_WHEEL  = 3'd4;

    // request commands
    localparam logic CMD_BYTE = 1'b0;
    localparam logic CMD_POP  = 1'b1;

    // configuration port
    localparam int PADDR_BITS = 4;

    typedef enum logic [1:0] {
        REG_BOUNDS_WIDTH   = 2'd0,
        REG_BOUNDS_HEIGHT  = 2'd1,
        REG_WHEEL_MODE     = 2'd2,
        REG_DEVICE_PRESENT = 2'd3
    } cfg_reg_t;

    // fifo control and status between tracker and wheel fifo
    typedef struct packed {
        logic       push;
        logic       pop;
        logic [7:0] data;
    } fifo_req_t;

    typedef struct packed {
        logic popped;
        logic overflow;
    } fifo_stat_t;

    // circular pointer advance
    function automatic logic [WHEEL_AW-1:0] ptr_inc(input logic [WHEEL_AW-1:0] p);
        logic [WHEEL_AW-1:0] r;
        if (p == WHEEL_AW'(WHEEL_DEPTH - 1))
        begin
            r = '0;
        end
        else
        begin
            r = p + WHEEL_AW'(1);
        end
        return r;
    endfunction

endpackage

@@ sv/ps2mt_wheel_fifo.sv @@
// ----------------------------------------------------------------------------
// ps2mt_wheel_fifo
// wheel step fifo in a synchronous memory, one slot kept free for full
// ----------------------------------------------------------------------------
module ps2mt_wheel_fifo (
    input  logic                  clk,
    input  logic                  rst_n,
    input  ps2mt_pkg::fifo_req_t  req,
    output ps2mt_pkg::fifo_stat_t stat,
    output logic [7:0]            rdata
);

    logic [7:0]                    mem [ps2mt_pkg::WHEEL_DEPTH];
    logic [ps2mt_pkg::WHEEL_AW-1:0] rd_ptr_reg;
    logic [ps2mt_pkg::WHEEL_AW-1:0] rd_ptr_next;
    logic [ps2mt_pkg::WHEEL_AW-1:0] wr_ptr_reg;
    logic [ps2mt_pkg::WHEEL_AW-1:0] wr_ptr_next;
    logic [7:0]                    rdata_reg;
    logic                          empty;
    logic                          full;
    logic                          wr_en;

    // occupancy
    assign empty = (wr_ptr_reg == rd_ptr_reg);
    assign full  = (ps2mt_pkg::ptr_inc(wr_ptr_reg) == rd_ptr_reg);

    assign wr_en         = req.push && !full;
    assign stat.popped   = req.pop && !empty;
    assign stat.overflow = req.push && full;

    // pointer update
    always_comb
    begin
        rd_ptr_next = rd_ptr_reg;
        wr_ptr_next = wr_ptr_reg;
        if (stat.popped)
        begin
            rd_ptr_next = ps2mt_pkg::ptr_inc(rd_ptr_reg);
        end
        if (wr_en)
        begin
            wr_ptr_next = ps2mt_pkg::ptr_inc(wr_ptr_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_ptr_reg <= '0;
            wr_ptr_reg <= '0;
        end
        else
        begin
            rd_ptr_reg <= rd_ptr_next;
            wr_ptr_reg <= wr_ptr_next;
        end
    end

    // storage, registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_ptr_reg] <= req.data;
        end
        if (stat.popped)
        begin
            rdata_reg <= mem[rd_ptr_reg];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ sv/ps2_mouse_packet_tracker.sv @@
// ----------------------------------------------------------------------------
// ps2_mouse_packet_tracker
// assembles ps2 mouse packets, tracks a clamped cursor and queues wheel steps
// ----------------------------------------------------------------------------
// channel  dir  handshake           payload
// in       in   in_valid/in_stall   command, data_byte
// out      out  out_valid/out_stall cursor_x .. event_count
// cfg      in   apb psel/penable    bounds, wheel_mode, device_present
//
// one request per cycle while in_stall is low; a result passes the memory read stage and then the output register
// packet state is registered on acceptance; the fifo memory read is registered
// reset clears pointers and packet state, the fifo memory is not cleared
// out_stall holds the output register; the request side stalls only when
// both the memory read stage and the output register are full
// ----------------------------------------------------------------------------
module ps2_mouse_packet_tracker (
    input  logic                                   clk,
    input  logic                                   rst_n,
    // request channel
    input  logic                                   in_valid,
    output logic                                   in_stall,
    input  logic                                   command,
    input  logic [7:0]                             data_byte,
    // result channel
    output logic                                   out_valid,
    input  logic                                   out_stall,
    output logic [ps2mt_pkg::COORD_BITS-1:0]       cursor_x,
    output logic [ps2mt_pkg::COORD_BITS-1:0]       cursor_y,
    output logic [2:0]                             buttons,
    output logic                                   packet_done,
    output logic                                   sync_dropped,
    output logic                                   wheel_overflow,
    output logic signed [7:0]                      wheel_value,
    output logic                                   wheel_valid,
    output logic [31:0]                            event_count,
    // configuration port
    input  logic                                   psel,
    input  logic                                   penable,
    input  logic                                   pwrite,
    input  logic [ps2mt_pkg::PADDR_BITS-1:0]       paddr,
    input  logic [31:0]                            pwdata,
    output logic [31:0]                            prdata,
    output logic                                   pready
);

    typedef struct packed {
        logic [ps2mt_pkg::COORD_BITS-1:0] x;
        logic [ps2mt_pkg::COORD_BITS-1:0] y;
        logic [2:0]                       buttons;
        logic                             done;
        logic                             dropped;
        logic                             overflow;
        logic                             wvalid;
        logic [31:0]                      count;
    } result_t;

    // configuration registers
    logic [ps2mt_pkg::BOUND_BITS-1:0] width_reg;
    logic [ps2mt_pkg::BOUND_BITS-1:0] height_reg;
    logic                             wheel_mode_reg;
    logic                             present_reg;
    logic                             cfg_write;
    ps2mt_pkg::cfg_reg_t              cfg_sel;

    // packet state
    logic [1:0]                       pos_reg,     pos_next;
    logic [7:0]                       header_reg,  header_next;
    logic [7:0]                       xbyte_reg,   xbyte_next;
    logic [7:0]                       ybyte_reg,   ybyte_next;
    logic [ps2mt_pkg::COORD_BITS-1:0] posx_reg,    posx_next;
    logic [ps2mt_pkg::COORD_BITS-1:0] posy_reg,    posy_next;
    logic [2:0]                       button_reg,  button_next;
    logic [31:0]                      count_reg,   count_next;

    // step signals
    logic                             accept;
    logic                             byte_active;
    logic                             done;
    logic                             dropped;
    logic                             push_req;
    logic [2:0]                       pos_inc;
    logic [2:0]                       pkt_len;
    logic signed [8:0]                dx;
    logic signed [8:0]                dy;
    logic signed [ps2mt_pkg::SUM_BITS-1:0] sum_x;
    logic signed [ps2mt_pkg::SUM_BITS-1:0] sum_y;

    // fifo
    ps2mt_pkg::fifo_req_t             fifo_req;
    ps2mt_pkg::fifo_stat_t            fifo_stat;
    logic [7:0]                       fifo_rdata;

    // pipeline
    logic                             s1_valid_reg;
    result_t                          s1_reg;
    result_t                          s1_next;
    logic                             s1_advance;
    logic                             out_valid_reg;
    result_t                          out_reg;
    logic [7:0]                       wvalue_reg;

    // clamp a moved coordinate to 0 .. bound-1, to 0 for a zero bound and to COORD_MAX above BOUND_FULL
    function automatic logic [ps2mt_pkg::COORD_BITS-1:0] clamp_axis(
        input logic signed [ps2mt_pkg::SUM_BITS-1:0] v,
        input logic [ps2mt_pkg::BOUND_BITS-1:0]      bound
    );
        logic [ps2mt_pkg::COORD_BITS-1:0] lim;
        logic [ps2mt_pkg::BOUND_BITS-1:0] bm1;
        logic [ps2mt_pkg::COORD_BITS-1:0] r;
        bm1 = bound - ps2mt_pkg::BOUND_BITS'(1);
        if (bound == '0)
        begin
            lim = '0;
        end
        else if (bound > ps2mt_pkg::BOUND_FULL)
        begin
            lim = ps2mt_pkg::COORD_MAX;
        end
        else
        begin
            lim = bm1[ps2mt_pkg::COORD_BITS-1:0];
        end
        if (v < 0)
        begin
            r = '0;
        end
        else if (v > $signed({2'b00, lim}))
        begin
            r = lim;
        end
        else
        begin
            r = v[ps2mt_pkg::COORD_BITS-1:0];
        end
        return r;
    endfunction

    // configuration port
    assign pready    = 1'b1;
    assign cfg_sel   = ps2mt_pkg::cfg_reg_t'(paddr[3:2]);
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg      <= ps2mt_pkg::WIDTH_RESET;
            height_reg     <= ps2mt_pkg::HEIGHT_RESET;
            wheel_mode_reg <= 1'b0;
            present_reg    <= 1'b0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_sel)
                ps2mt_pkg::REG_BOUNDS_WIDTH:   width_reg      <= pwdata[ps2mt_pkg::BOUND_BITS-1:0];
                ps2mt_pkg::REG_BOUNDS_HEIGHT:  height_reg     <= pwdata[ps2mt_pkg::BOUND_BITS-1:0];
                ps2mt_pkg::REG_WHEEL_MODE:     wheel_mode_reg <= pwdata[0];
                ps2mt_pkg::REG_DEVICE_PRESENT: present_reg    <= pwdata[0];
            endcase
        end
    end

    // register readback
    always_comb
    begin
        unique case (cfg_sel)
            ps2mt_pkg::REG_BOUNDS_WIDTH:   prdata = 32'(width_reg);
            ps2mt_pkg::REG_BOUNDS_HEIGHT:  prdata = 32'(height_reg);
            ps2mt_pkg::REG_WHEEL_MODE:     prdata = 32'(wheel_mode_reg);
            ps2mt_pkg::REG_DEVICE_PRESENT: prdata = 32'(present_reg);
        endcase
    end

    // request handshake
    assign s1_advance  = s1_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall    = s1_valid_reg && !s1_advance;
    assign accept      = in_valid && !in_stall;
    assign byte_active = accept && (command == ps2mt_pkg::CMD_BYTE) && present_reg;

    // packet assembly, cursor move and clamp
    assign pos_inc = {1'b0, pos_reg} + 3'd1;
    assign pkt_len = wheel_mode_reg ? ps2mt_pkg::LEN_WHEEL : ps2mt_pkg::LEN_PLAIN;
    assign dx      = $signed({header_reg[ps2mt_pkg::X_SIGN_BIT], xbyte_next});
    assign dy      = $signed({header_reg[ps2mt_pkg::Y_SIGN_BIT], ybyte_next});
    assign sum_x   = $signed({2'b00, posx_reg})
                   + $signed({{(ps2mt_pkg::SUM_BITS-9){dx[8]}}, dx});
    assign sum_y   = $signed({2'b00, posy_reg})
                   - $signed({{(ps2mt_pkg::SUM_BITS-9){dy[8]}}, dy});

    always_comb
    begin
        pos_next    = pos_reg;
        header_next = header_reg;
        xbyte_next  = xbyte_reg;
        ybyte_next  = ybyte_reg;
        posx_next   = posx_reg;
        posy_next   = posy_reg;
        button_next = button_reg;
        done        = 1'b0;
        dropped     = 1'b0;
        push_req    = 1'b0;
        if (byte_active)
        begin
            if (pos_reg == ps2mt_pkg::POS_HEADER)
            begin
                if (!data_byte[ps2mt_pkg::SYNC_BIT])
                begin
                    dropped = 1'b1;
                end
                else
                begin
                    header_next = data_byte;
                    pos_next    = ps2mt_pkg::POS_X;
                end
            end
            else
            begin
                if (pos_reg == ps2mt_pkg::POS_X)
                begin
                    xbyte_next = data_byte;
                end
                if (pos_reg == ps2mt_pkg::POS_Y)
                begin
                    ybyte_next = data_byte;
                end
                if (pos_inc >= pkt_len)
                begin
                    pos_next    = ps2mt_pkg::POS_HEADER;
                    done        = 1'b1;
                    button_next = header_reg[2:0];
                    posx_next   = clamp_axis(sum_x, width_reg);
                    posy_next   = clamp_axis(sum_y, height_reg);
                    push_req    = wheel_mode_reg && (pos_inc == ps2mt_pkg::LEN_WHEEL)
                                  && (data_byte != 8'd0);
                end
                else
                begin
                    pos_next = pos_inc[1:0];
                end
            end
        end
    end

    // received byte counter
    assign count_next = (accept && (command == ps2mt_pkg::CMD_BYTE))
                      ? count_reg + 32'd1 : count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg    <= ps2mt_pkg::POS_HEADER;
            header_reg <= '0;
            xbyte_reg  <= '0;
            ybyte_reg  <= '0;
            posx_reg   <= ps2mt_pkg::POS_X_RESET;
            posy_reg   <= ps2mt_pkg::POS_Y_RESET;
            button_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            pos_reg    <= pos_next;
            header_reg <= header_next;
            xbyte_reg  <= xbyte_next;
            ybyte_reg  <= ybyte_next;
            posx_reg   <= posx_next;
            posy_reg   <= posy_next;
            button_reg <= button_next;
            count_reg  <= count_next;
        end
    end

    // wheel fifo
    assign fifo_req.push = push_req;
    assign fifo_req.pop  = accept && (command == ps2mt_pkg::CMD_POP);
    assign fifo_req.data = data_byte;

    ps2mt_wheel_fifo u_wheel_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (fifo_req),
        .stat  (fifo_stat),
        .rdata (fifo_rdata)
    );

    // memory read stage
    always_comb
    begin
        s1_next.x        = posx_next;
        s1_next.y        = posy_next;
        s1_next.buttons  = button_next;
        s1_next.done     = done;
        s1_next.dropped  = dropped;
        s1_next.overflow = fifo_stat.overflow;
        s1_next.wvalid   = fifo_stat.popped;
        s1_next.count    = count_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (s1_advance)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_reg <= s1_next;
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_advance)
        begin
            out_reg    <= s1_reg;
            wvalue_reg <= s1_reg.wvalid ? fifo_rdata : 8'd0;
        end
    end

    assign out_valid      = out_valid_reg;
    assign cursor_x       = out_reg.x;
    assign cursor_y       = out_reg.y;
    assign buttons        = out_reg.buttons;
    assign packet_done    = out_reg.done;
    assign sync_dropped   = out_reg.dropped;
    assign wheel_overflow = out_reg.overflow;
    assign wheel_value    = $signed(wvalue_reg);
    assign wheel_valid    = out_reg.wvalid;
    assign event_count    = out_reg.count;

endmodule

@@ sv/ps2mt_checker.sv @@
// ----------------------------------------------------------------------------
// ps2mt_checker
// port-level checks of the ps2 mouse packet tracker results
// ----------------------------------------------------------------------------
`include "ps2_mouse_packet_tracker_assert.svh"

module ps2mt_checker (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             out_valid,
    input logic                             out_stall,
    input logic [ps2mt_pkg::COORD_BITS-1:0] cursor_x,
    input logic                             packet_done,
    input logic                             sync_dropped,
    input logic                             wheel_overflow,
    input logic signed [7:0]                wheel_value,
    input logic                             wheel_valid,
    input logic [31:0]                      event_count
);

    // an empty pop or a byte request carries no wheel step
    `PS2MT_ASSERT_IMPLIES(a_wheel_zero, out_valid && !wheel_valid, wheel_value == 8'sd0)

    // a pop request never reports packet status
    `PS2MT_ASSERT_IMPLIES(a_pop_flags, out_valid && wheel_valid, !packet_done && !sync_dropped && !wheel_overflow)

    // a dropped header cannot finish a packet
    `PS2MT_ASSERT_IMPLIES(a_done_drop, out_valid, !(packet_done && sync_dropped))

    // fifo overflow only on the last byte of a packet
    `PS2MT_ASSERT_IMPLIES(a_ovf_done, out_valid && wheel_overflow, packet_done)

    // stalled result holds
    `PS2MT_ASSERT_NEXT(a_hold, out_valid && out_stall, out_valid && $stable(cursor_x) && $stable(event_count) && $stable(wheel_value))

endmodule

bind ps2_mouse_packet_tracker ps2mt_checker u_ps2mt_checker (.*);

@@ tb/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// drives mouse bytes and wheel pops into the packet tracker, predicts every
// result from a behavioral copy of the tracker state and checks each one
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;

    localparam int CYCLE_LIMIT   = 200000;
    localparam int DRAIN_LIMIT   = 5000;
    localparam int LATENCY_PAUSE = 4;
    localparam int HOLD_CYCLES   = 200;
    localparam int MAX_PRINTED   = 20;

    // one result as seen on the output channel
    typedef struct packed {
        logic [ps2mt_pkg::COORD_BITS-1:0] cursor_x;
        logic [ps2mt_pkg::COORD_BITS-1:0] cursor_y;
        logic [2:0]                       buttons;
        logic                             packet_done;
        logic                             sync_dropped;
        logic                             wheel_overflow;
        logic [7:0]                       wheel_value;
        logic                             wheel_valid;
        logic [31:0]                      event_count;
    } tracker_report_t;

    // behavioral tracker state plus the queue of results still owed
    class tracker_scoreboard;
        logic [ps2mt_pkg::BOUND_BITS-1:0] bound_w;
        logic [ps2mt_pkg::BOUND_BITS-1:0] bound_h;
        logic                             wheel_on;
        logic                             mouse_on;
        logic [1:0]                       byte_pos;
        logic [7:0]                       hdr;
        logic [7:0]                       x_raw;
        logic [7:0]                       y_raw;
        logic [ps2mt_pkg::COORD_BITS-1:0] cur_x;
        logic [ps2mt_pkg::COORD_BITS-1:0] cur_y;
        logic [2:0]                       btn;
        logic [7:0]                       wheel_mem [ps2mt_pkg::WHEEL_DEPTH];
        int                               rd_ptr;
        int                               wr_ptr;
        logic [31:0]                      byte_count;
        tracker_report_t                  expected_reports [$];
        int                               mismatches;
        int                               checked;
        int                               packets;
        int                               drops;
        int                               overflows;
        int                               steps_popped;

        function new();
            bound_w      = ps2mt_pkg::WIDTH_RESET;
            bound_h      = ps2mt_pkg::HEIGHT_RESET;
            wheel_on     = 1'b0;
            mouse_on     = 1'b0;
            byte_pos     = ps2mt_pkg::POS_HEADER;
            hdr          = '0;
            x_raw        = '0;
            y_raw        = '0;
            cur_x        = ps2mt_pkg::POS_X_RESET;
            cur_y        = ps2mt_pkg::POS_Y_RESET;
            btn          = '0;
            rd_ptr       = 0;
            wr_ptr       = 0;
            byte_count   = '0;
            mismatches   = 0;
            checked      = 0;
            packets      = 0;
            drops        = 0;
            overflows    = 0;
            steps_popped = 0;
        endfunction

        function void write_register(ps2mt_pkg::cfg_reg_t sel, logic [31:0] value);
            case (sel)
                ps2mt_pkg::REG_BOUNDS_WIDTH:   bound_w = value[ps2mt_pkg::BOUND_BITS-1:0];
                ps2mt_pkg::REG_BOUNDS_HEIGHT:  bound_h = value[ps2mt_pkg::BOUND_BITS-1:0];
                ps2mt_pkg::REG_WHEEL_MODE:     wheel_on = value[0];
                ps2mt_pkg::REG_DEVICE_PRESENT: mouse_on = value[0];
                default:                       ;
            endcase
        endfunction

        // zero bound behaves as one, oversized bound as the full coordinate range
        function int pin_to_bounds(int v, logic [ps2mt_pkg::BOUND_BITS-1:0] bound);
            int lim;
            if (bound == 0)
            begin
                lim = 0;
            end
            else if (bound > ps2mt_pkg::BOUND_FULL)
            begin
                lim = int'(ps2mt_pkg::BOUND_FULL) - 1;
            end
            else
            begin
                lim = int'(bound) - 1;
            end
            if (v < 0)
            begin
                return 0;
            end
            if (v > lim)
            begin
                return lim;
            end
            return v;
        endfunction

        // advance the tracker by one accepted request and queue its result
        function void note_request(logic cmd, logic [7:0] data);
            tracker_report_t r;
            int next_pos;
            int pkt_len;
            int dx;
            int dy;
            int nxt;
            r = '0;
            if (cmd == ps2mt_pkg::CMD_POP)
            begin
                if (rd_ptr != wr_ptr)
                begin
                    r.wheel_value = wheel_mem[rd_ptr];
                    r.wheel_valid = 1'b1;
                    rd_ptr = (rd_ptr + 1) % ps2mt_pkg::WHEEL_DEPTH;
                    steps_popped++;
                end
            end
            else
            begin
                byte_count = byte_count + 32'd1;
                if (mouse_on)
                begin
                    if (byte_pos == ps2mt_pkg::POS_HEADER)
                    begin
                        if (!data[ps2mt_pkg::SYNC_BIT])
                        begin
                            r.sync_dropped = 1'b1;
                            drops++;
                        end
                        else
                        begin
                            hdr = data;
                            byte_pos = ps2mt_pkg::POS_X;
                        end
                    end
                    else
                    begin
                        if (byte_pos == ps2mt_pkg::POS_X)
                        begin
                            x_raw = data;
                        end
                        else if (byte_pos == ps2mt_pkg::POS_Y)
                        begin
                            y_raw = data;
                        end
                        next_pos = int'(byte_pos) + 1;
                        pkt_len = wheel_on ? int'(ps2mt_pkg::LEN_WHEEL)
                                           : int'(ps2mt_pkg::LEN_PLAIN);
                        if (next_pos >= pkt_len)
                        begin
                            // 9-bit two's complement motion, sign from the header
                            dx = hdr[ps2mt_pkg::X_SIGN_BIT] ? int'(x_raw) - 256 : int'(x_raw);
                            dy = hdr[ps2mt_pkg::Y_SIGN_BIT] ? int'(y_raw) - 256 : int'(y_raw);
                            byte_pos = ps2mt_pkg::POS_HEADER;
                            r.packet_done = 1'b1;
                            packets++;
                            btn = hdr[2:0];
                            cur_x = ps2mt_pkg::COORD_BITS'(
                                pin_to_bounds(int'(cur_x) + dx, bound_w));
                            cur_y = ps2mt_pkg::COORD_BITS'(
                                pin_to_bounds(int'(cur_y) - dy, bound_h));
                            if (wheel_on && next_pos == int'(ps2mt_pkg::LEN_WHEEL)
                                && data != 8'h00)
                            begin
                                nxt = (wr_ptr + 1) % ps2mt_pkg::WHEEL_DEPTH;
                                if (nxt != rd_ptr)
                                begin
                                    wheel_mem[wr_ptr] = data;
                                    wr_ptr = nxt;
                                end
                                else
                                begin
                                    r.wheel_overflow = 1'b1;
                                    overflows++;
                                end
                            end
                        end
                        else
                        begin
                            byte_pos = 2'(next_pos);
                        end
                    end
                end
            end
            r.cursor_x    = cur_x;
            r.cursor_y    = cur_y;
            r.buttons     = btn;
            r.event_count = byte_count;
            expected_reports.push_back(r);
        endfunction

        task report_mismatch(string what);
            if (mismatches < MAX_PRINTED)
            begin
                $display("mismatch at result %0d: %s", checked, what);
            end
            mismatches++;
        endtask

        // compare one accepted result against the oldest expectation
        task check_report(tracker_report_t got);
            tracker_report_t want;
            if (expected_reports.size() == 0)
            begin
                report_mismatch("result arrived with no request pending");
                return;
            end
            want = expected_reports.pop_front();
            if (got.cursor_x !== want.cursor_x)
                report_mismatch($sformatf("cursor_x %0d, want %0d",
                    got.cursor_x, want.cursor_x));
            if (got.cursor_y !== want.cursor_y)
                report_mismatch($sformatf("cursor_y %0d, want %0d",
                    got.cursor_y, want.cursor_y));
            if (got.buttons !== want.buttons)
                report_mismatch($sformatf("buttons %0d, want %0d",
                    got.buttons, want.buttons));
            if (got.packet_done !== want.packet_done)
                report_mismatch($sformatf("packet_done %0b, want %0b",
                    got.packet_done, want.packet_done));
            if (got.sync_dropped !== want.sync_dropped)
                report_mismatch($sformatf("sync_dropped %0b, want %0b",
                    got.sync_dropped, want.sync_dropped));
            if (got.wheel_overflow !== want.wheel_overflow)
                report_mismatch($sformatf("wheel_overflow %0b, want %0b",
                    got.wheel_overflow, want.wheel_overflow));
            if (got.wheel_value !== want.wheel_value)
                report_mismatch($sformatf("wheel_value %0d, want %0d",
                    $signed(got.wheel_value), $signed(want.wheel_value)));
            if (got.wheel_valid !== want.wheel_valid)
                report_mismatch($sformatf("wheel_valid %0b, want %0b",
                    got.wheel_valid, want.wheel_valid));
            if (got.event_count !== want.event_count)
                report_mismatch($sformatf("event_count %0d, want %0d",
                    got.event_count, want.event_count));
            checked++;
        endtask
    endclass

    logic                             clk;
    logic                             rst_n = 1'b0;
    logic                             in_valid = 1'b0;
    logic                             in_stall;
    logic                             command = ps2mt_pkg::CMD_BYTE;
    logic [7:0]                       data_byte = '0;
    logic                             out_valid;
    logic                             out_stall = 1'b0;
    logic [ps2mt_pkg::COORD_BITS-1:0] cursor_x;
    logic [ps2mt_pkg::COORD_BITS-1:0] cursor_y;
    logic [2:0]                       buttons;
    logic                             packet_done;
    logic                             sync_dropped;
    logic                             wheel_overflow;
    logic signed [7:0]                wheel_value;
    logic                             wheel_valid;
    logic [31:0]                      event_count;
    logic                             psel = 1'b0;
    logic                             penable = 1'b0;
    logic                             pwrite = 1'b0;
    logic [ps2mt_pkg::PADDR_BITS-1:0] paddr = '0;
    logic [31:0]                      pwdata = '0;
    logic [31:0]                      prdata;
    logic                             pready;

    tracker_scoreboard sb;
    int                send_idle_pct = 30;
    int                recv_idle_pct = 60;
    bit                hold_wanted = 1'b0;
    int                cycle_count = 0;
    logic [8:0]        opening [$];

    ps2_mouse_packet_tracker dut (.*);

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // run limit
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("run stopped at the cycle limit with %0d results outstanding",
            sb.expected_reports.size());
        $display("FAIL");
        $finish;
    end

    // result side: random stalls, one long hold-off on request, result checks
    initial
    begin
        int              hold_left;
        tracker_report_t seen;
        hold_left = 0;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && !out_stall)
            begin
                seen = '{cursor_x, cursor_y, buttons, packet_done, sync_dropped,
                         wheel_overflow, wheel_value, wheel_valid, event_count};
                sb.check_report(seen);
            end
            if (hold_wanted)
            begin
                hold_left = HOLD_CYCLES;
                hold_wanted = 1'b0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else
            begin
                out_stall <= ($urandom_range(99) < recv_idle_pct);
            end
        end
    end

    // offer one request, with random idle cycles first, and wait for acceptance
    task send_request(logic cmd, logic [7:0] data);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid  <= 1'b1;
        command   <= cmd;
        data_byte <= data;
        do
            @(posedge clk);
        while (in_stall);
        sb.note_request(cmd, data);
    endtask

    // well-formed packet with random content; only the first keep bytes go out
    task send_packet(int keep);
        logic [7:0] pkt [4];
        int         i;
        pkt[0] = 8'($urandom);
        pkt[0][ps2mt_pkg::SYNC_BIT] = 1'b1;
        pkt[1] = 8'($urandom);
        pkt[2] = 8'($urandom);
        if ($urandom_range(3) == 0)
            pkt[1] = pkt[0][ps2mt_pkg::X_SIGN_BIT] ? 8'h00 : 8'hFF;
        if ($urandom_range(3) == 0)
            pkt[2] = pkt[0][ps2mt_pkg::Y_SIGN_BIT] ? 8'h00 : 8'hFF;
        pkt[3] = ($urandom_range(3) == 0) ? 8'h00 : 8'($urandom);
        for (i = 0; i < keep; i++)
        begin
            send_request(ps2mt_pkg::CMD_BYTE, pkt[i]);
        end
    endtask

    // wait for all results, then pause before touching registers
    task wait_drained();
        int guard;
        guard = 0;
        in_valid <= 1'b0;
        while (sb.expected_reports.size() != 0 && guard < DRAIN_LIMIT)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (LATENCY_PAUSE) @(posedge clk);
    endtask

    // apb write: setup cycle, then access cycle until pready
    task program_register(ps2mt_pkg::cfg_reg_t sel, logic [31:0] value);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ps2mt_pkg::PADDR_BITS'(4 * int'(sel));
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        sb.write_register(sel, value);
    endtask

    // one setting of the registers followed by a stretch of random traffic
    task run_segment(int w, int h, bit mode, bit present, int items, int pop_pct,
                     int s_idle, int r_idle, bit hold_off);
        int sent;
        int pick;
        int len;
        wait_drained();
        program_register(ps2mt_pkg::REG_BOUNDS_WIDTH, w);
        program_register(ps2mt_pkg::REG_BOUNDS_HEIGHT, h);
        program_register(ps2mt_pkg::REG_WHEEL_MODE, mode);
        program_register(ps2mt_pkg::REG_DEVICE_PRESENT, present);
        send_idle_pct = s_idle;
        recv_idle_pct = r_idle;
        if (hold_off)
            hold_wanted = 1'b1;
        len = mode ? int'(ps2mt_pkg::LEN_WHEEL) : int'(ps2mt_pkg::LEN_PLAIN);
        sent = 0;
        while (sent < items)
        begin
            pick = $urandom_range(99);
            if (pick < pop_pct)
            begin
                send_request(ps2mt_pkg::CMD_POP, 8'($urandom));
                sent++;
            end
            else if (pick < pop_pct + 6)
            begin
                // stray byte, may start a misaligned packet
                send_request(ps2mt_pkg::CMD_BYTE, 8'($urandom));
                sent++;
            end
            else
            begin
                send_packet(len);
                sent += len;
            end
        end
        // may leave a packet unfinished so the next setting can start mid-packet
        send_packet($urandom_range(len - 1));
    endtask

    // main sequence
    initial
    begin
        sb = new();
        opening = '{
            {ps2mt_pkg::CMD_BYTE, 8'h00}, {ps2mt_pkg::CMD_BYTE, 8'hF7},
            {ps2mt_pkg::CMD_POP, 8'h00},
            {ps2mt_pkg::CMD_BYTE, 8'h0F}, {ps2mt_pkg::CMD_BYTE, 8'hFF},
            {ps2mt_pkg::CMD_BYTE, 8'h00}, {ps2mt_pkg::CMD_BYTE, 8'h01},
            {ps2mt_pkg::CMD_BYTE, 8'h38}, {ps2mt_pkg::CMD_BYTE, 8'h00},
            {ps2mt_pkg::CMD_BYTE, 8'h00}, {ps2mt_pkg::CMD_BYTE, 8'h80},
            {ps2mt_pkg::CMD_BYTE, 8'h1F}, {ps2mt_pkg::CMD_BYTE, 8'h01},
            {ps2mt_pkg::CMD_BYTE, 8'hFF}, {ps2mt_pkg::CMD_BYTE, 8'h00},
            {ps2mt_pkg::CMD_BYTE, 8'h2B}, {ps2mt_pkg::CMD_BYTE, 8'h7F},
            {ps2mt_pkg::CMD_BYTE, 8'h00}, {ps2mt_pkg::CMD_BYTE, 8'h7F},
            {ps2mt_pkg::CMD_POP, 8'hA5}, {ps2mt_pkg::CMD_POP, 8'h5A},
            {ps2mt_pkg::CMD_POP, 8'hFF}, {ps2mt_pkg::CMD_POP, 8'h00}
        };
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // no device after reset: bytes only counted, pop on an empty queue
        send_request(ps2mt_pkg::CMD_BYTE, 8'h0F);
        send_request(ps2mt_pkg::CMD_POP, 8'h3C);
        wait_drained();
        program_register(ps2mt_pkg::REG_BOUNDS_WIDTH, 4096);
        program_register(ps2mt_pkg::REG_BOUNDS_HEIGHT, 4096);
        program_register(ps2mt_pkg::REG_WHEEL_MODE, 1);
        program_register(ps2mt_pkg::REG_DEVICE_PRESENT, 1);

        // sync drops, extreme motions, wheel pushes and pops down to empty
        foreach (opening[i])
        begin
            send_request(opening[i][8], opening[i][7:0]);
        end

        // random traffic under several register settings
        run_segment(8191, 8191, 1'b1, 1'b1, 500, 3, 30, 60, 1'b0);
        run_segment(1, 0, 1'b0, 1'b1, 150, 10, 30, 60, 1'b0);
        run_segment(640, 4097, 1'b1, 1'b1, 500, 40, 60, 30, 1'b0);
        run_segment(2000, 100, 1'b1, 1'b0, 40, 20, 60, 30, 1'b0);
        run_segment($urandom_range(1, 4096), $urandom_range(1, 4096), 1'b0, 1'b1,
            380, 10, 0, 0, 1'b1);
        run_segment(320, 200, 1'b1, 1'b1, 380, 20, 0, 0, 1'b0);
        wait_drained();

        if (sb.expected_reports.size() != 0)
        begin
            sb.report_mismatch($sformatf("%0d results never arrived",
                sb.expected_reports.size()));
        end
        $display("checked %0d results: %0d packets, %0d sync drops, %0d wheel pops",
            sb.checked, sb.packets, sb.drops, sb.steps_popped);
        $display("wheel queue overflowed %0d times; %0d mismatches in %0d cycles",
            sb.overflows, sb.mismatches, cycle_count);
        if (sb.mismatches == 0)
        begin
            $display("PASS");
        end
        else
        begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
